// ===== design/rmv_pkg.sv =====
// Shared types, constants and helpers for the running statistics block.
package rmv_pkg;

    localparam int DATA_W = 32;
    localparam int COUNT_OUT_W = 24;
    localparam int ACTION_W = 2;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF = 24;
    localparam int SAMPLE_WIDTH_MAX = 48;
    localparam int NUM_W = 64;
    localparam int M2_W = 64;
    localparam int ROOT_W = 32;
    localparam int STEP_W = 7;
    localparam int PRODX_W = 2 * SAMPLE_WIDTH_MAX;

    localparam logic [ACTION_W-1:0] ACT_ADD = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REPORT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_DIV,
        OP_MUL,
        OP_SQRT
    } op_t;

    typedef struct packed {
        logic              start;
        op_t               op;
        logic [STEP_W-1:0] steps;
    } unit_cmd_t;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== design/rmv_iter_unit.sv =====
// Shared radix-2 unit: restoring divide, digit-by-digit square root, shift-add multiply.
module rmv_iter_unit #(
    parameter int SAMPLE_WIDTH = rmv_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH = rmv_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  rmv_pkg::unit_cmd_t                                     cmd,
    input  logic [rmv_pkg::NUM_W-1:0]                              num,
    input  logic [rmv_pkg::max2(SAMPLE_WIDTH, COUNT_WIDTH)-1:0]    opnd,
    output logic                                                   done,
    output logic [rmv_pkg::NUM_W-1:0]                              quo,
    output logic [SAMPLE_WIDTH-1:0]                                hi,
    output logic [rmv_pkg::ROOT_W-1:0]                             root
);

    localparam int OPND_W = rmv_pkg::max2(SAMPLE_WIDTH, COUNT_WIDTH);
    localparam int ADD_W = rmv_pkg::max2(rmv_pkg::max2(SAMPLE_WIDTH + 1, COUNT_WIDTH + 2),
                                         rmv_pkg::ROOT_W + 4);
    localparam int NUM_W = rmv_pkg::NUM_W;
    localparam int ROOT_W = rmv_pkg::ROOT_W;
    localparam int STEP_W = rmv_pkg::STEP_W;

    rmv_pkg::op_t        op_reg, op_next;
    logic [OPND_W-1:0]   opnd_reg, opnd_next;
    logic [ADD_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [ADD_W-1:0]    add_a;
    logic [ADD_W-1:0]    add_b;
    logic                add_sub;
    logic [ADD_W:0]      add_res;
    logic                ge;

    always_comb
    begin
        add_a = '0;
        add_b = '0;
        add_sub = 1'b0;
        unique case (op_reg)
            rmv_pkg::OP_DIV:
            begin
                add_a = {rem_reg[ADD_W-2:0], quo_reg[NUM_W-1]};
                add_b = ADD_W'(opnd_reg);
                add_sub = 1'b1;
            end
            rmv_pkg::OP_SQRT:
            begin
                add_a = {rem_reg[ADD_W-3:0], quo_reg[NUM_W-1:NUM_W-2]};
                add_b = ADD_W'({root_reg, 2'b01});
                add_sub = 1'b1;
            end
            rmv_pkg::OP_MUL:
            begin
                add_a = rem_reg;
                add_b = quo_reg[0] ? ADD_W'(opnd_reg) : '0;
                add_sub = 1'b0;
            end
            default:
            begin
                add_a = '0;
            end
        endcase
        add_res = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (ADD_W + 1)'(add_sub);
        ge = add_res[ADD_W];
    end

    always_comb
    begin
        op_next = op_reg;
        opnd_next = opnd_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        root_next = root_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            op_next = cmd.op;
            opnd_next = opnd;
            rem_next = '0;
            quo_next = num;
            root_next = '0;
            cnt_next = cmd.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                rmv_pkg::OP_DIV:
                begin
                    rem_next = ge ? add_res[ADD_W-1:0] : add_a;
                    quo_next = {quo_reg[NUM_W-2:0], ge};
                end
                rmv_pkg::OP_SQRT:
                begin
                    rem_next = ge ? add_res[ADD_W-1:0] : add_a;
                    quo_next = {quo_reg[NUM_W-3:0], 2'b00};
                    root_next = {root_reg[ROOT_W-2:0], ge};
                end
                rmv_pkg::OP_MUL:
                begin
                    rem_next = add_res[ADD_W:1];
                    quo_next = quo_reg >> 1;
                    quo_next[SAMPLE_WIDTH-1] = add_res[0];
                end
                default:
                begin
                    rem_next = rem_reg;
                end
            endcase
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= rmv_pkg::OP_DIV;
            opnd_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
            root_reg <= '0;
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            op_reg <= op_next;
            opnd_reg <= opnd_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            root_reg <= root_next;
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quo = quo_reg;
    assign hi = rem_reg[SAMPLE_WIDTH-1:0];
    assign root = root_reg;

endmodule

// ===== design/running_mean_variance_min_max.sv =====
// Add: a mean divide and then an M2 multiply, one product or quotient bit per cycle.
// Report: 64 quotient steps for M2/count plus 32 root steps.
// Clear and ignored adds complete in the idle state; an empty report passes through S_REPORT only.
// All work runs through one shared radix-2 unit; in_ready is low while it is busy.
// A result waits in the output register while the next item is taken.
// Asynchronous active-low reset empties the statistics and drops any pending result.
module running_mean_variance_min_max #(
    parameter int SAMPLE_WIDTH = rmv_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH = rmv_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [rmv_pkg::ACTION_W-1:0]          action,
    input  logic signed [rmv_pkg::DATA_W-1:0]     sample,
    input  logic                                  passes_cut,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [rmv_pkg::COUNT_OUT_W-1:0]       sample_count,
    output logic signed [rmv_pkg::DATA_W-1:0]     mean_value,
    output logic [rmv_pkg::DATA_W-1:0]            std_deviation,
    output logic signed [rmv_pkg::DATA_W-1:0]     smallest,
    output logic signed [rmv_pkg::DATA_W-1:0]     largest,
    output logic                                  is_empty
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = COUNT_WIDTH;
    localparam int DW = rmv_pkg::DATA_W;
    localparam int CO_W = rmv_pkg::COUNT_OUT_W;
    localparam int OPND_W = rmv_pkg::max2(SAMPLE_WIDTH, COUNT_WIDTH);
    localparam int NUM_W = rmv_pkg::NUM_W;
    localparam int M2_W = rmv_pkg::M2_W;
    localparam int ROOT_W = rmv_pkg::ROOT_W;
    localparam int STEP_W = rmv_pkg::STEP_W;
    localparam int PRODX_W = rmv_pkg::PRODX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEAN_DIV,
        S_MEAN_UPD,
        S_M2_MUL,
        S_VAR_DIV,
        S_STD_SQRT,
        S_REPORT
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic signed [SW-1:0]     mean_reg, mean_next;
    logic [M2_W-1:0]          m2_reg, m2_next;
    logic signed [SW-1:0]     min_reg, min_next;
    logic signed [SW-1:0]     max_reg, max_next;
    logic signed [SW-1:0]     x_reg, x_next;
    logic                     d1_neg_reg, d1_neg_next;
    logic [SW-1:0]            d1_mag_reg, d1_mag_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CO_W-1:0]          sample_count_reg, sample_count_next;
    logic [DW-1:0]            mean_value_reg, mean_value_next;
    logic [DW-1:0]            std_reg, std_next;
    logic [DW-1:0]            smallest_reg, smallest_next;
    logic [DW-1:0]            largest_reg, largest_next;
    logic                     is_empty_reg, is_empty_next;

    logic [SW+DW-1:0]         sample_ext;
    logic signed [SW-1:0]     x_in;
    logic [SW:0]              d1_diff;
    logic [SW:0]              d1_abs;
    logic [SW:0]              d2_diff;
    logic [SW:0]              d2_abs;
    logic [SW-1:0]            quot;
    logic [2*SW-1:0]          prod;
    logic [PRODX_W-1:0]       prod_ext;
    logic [M2_W-1:0]          inc;
    logic [M2_W:0]            m2_sum;
    logic [DW+SW-1:0]         mean_ext;
    logic [DW+SW-1:0]         min_ext;
    logic [DW+SW-1:0]         max_ext;
    logic [CO_W+CW-1:0]       count_ext;
    logic                     accept;

    rmv_pkg::unit_cmd_t       cmd;
    logic [NUM_W-1:0]         unit_num;
    logic [OPND_W-1:0]        unit_opnd;
    logic                     unit_done;
    logic [NUM_W-1:0]         unit_quo;
    logic [SW-1:0]            unit_hi;
    logic [ROOT_W-1:0]        unit_root;

    rmv_iter_unit #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_unit (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .num(unit_num),
        .opnd(unit_opnd),
        .done(unit_done),
        .quo(unit_quo),
        .hi(unit_hi),
        .root(unit_root)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;

    always_comb
    begin
        sample_ext = {{SW{1'b0}}, sample};
        x_in = sample_ext[SW-1:0];
        d1_diff = {x_in[SW-1], x_in} - {mean_reg[SW-1], mean_reg};
        d1_abs = d1_diff[SW] ? (~d1_diff + (SW + 1)'(1)) : d1_diff;
        d2_diff = {x_reg[SW-1], x_reg} - {mean_reg[SW-1], mean_reg};
        d2_abs = d2_diff[SW] ? (~d2_diff + (SW + 1)'(1)) : d2_diff;
        quot = unit_quo[SW-1:0];
        prod = {unit_hi, unit_quo[SW-1:0]};
        prod_ext = PRODX_W'(prod);
        inc = (|prod_ext[PRODX_W-1:M2_W]) ? '1 : prod_ext[M2_W-1:0];
        m2_sum = {1'b0, m2_reg} + {1'b0, inc};
        mean_ext = {{DW{mean_reg[SW-1]}}, mean_reg};
        min_ext = {{DW{min_reg[SW-1]}}, min_reg};
        max_ext = {{DW{max_reg[SW-1]}}, max_reg};
        count_ext = {{CO_W{1'b0}}, count_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        mean_next = mean_reg;
        m2_next = m2_reg;
        min_next = min_reg;
        max_next = max_reg;
        x_next = x_reg;
        d1_neg_next = d1_neg_reg;
        d1_mag_next = d1_mag_reg;
        out_valid_next = out_valid_reg && !out_ready;
        sample_count_next = sample_count_reg;
        mean_value_next = mean_value_reg;
        std_next = std_reg;
        smallest_next = smallest_reg;
        largest_next = largest_reg;
        is_empty_next = is_empty_reg;
        cmd.start = 1'b0;
        cmd.op = rmv_pkg::OP_DIV;
        cmd.steps = STEP_W'(SW);
        unit_num = '0;
        unit_opnd = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        rmv_pkg::ACT_ADD:
                        begin
                            if (passes_cut && !(&count_reg))
                            begin
                                if (x_in < min_reg)
                                begin
                                    min_next = x_in;
                                end
                                if (x_in > max_reg)
                                begin
                                    max_next = x_in;
                                end
                                count_next = count_reg + CW'(1);
                                x_next = x_in;
                                d1_neg_next = d1_diff[SW];
                                d1_mag_next = d1_abs[SW-1:0];
                                cmd.start = 1'b1;
                                cmd.op = rmv_pkg::OP_DIV;
                                cmd.steps = STEP_W'(SW);
                                unit_num = {d1_abs[SW-1:0], {(NUM_W - SW){1'b0}}};
                                unit_opnd = OPND_W'(count_next);
                                state_next = S_MEAN_DIV;
                            end
                        end
                        rmv_pkg::ACT_REPORT:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = S_REPORT;
                            end
                            else
                            begin
                                cmd.start = 1'b1;
                                cmd.op = rmv_pkg::OP_DIV;
                                cmd.steps = STEP_W'(NUM_W);
                                unit_num = m2_reg;
                                unit_opnd = OPND_W'(count_reg);
                                state_next = S_VAR_DIV;
                            end
                        end
                        rmv_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                            mean_next = '0;
                            m2_next = '0;
                            min_next = {1'b0, {(SW - 1){1'b1}}};
                            max_next = {1'b1, {(SW - 1){1'b0}}};
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MEAN_DIV:
            begin
                if (unit_done)
                begin
                    mean_next = d1_neg_reg ? (mean_reg - quot) : (mean_reg + quot);
                    state_next = S_MEAN_UPD;
                end
            end
            S_MEAN_UPD:
            begin
                cmd.start = 1'b1;
                cmd.op = rmv_pkg::OP_MUL;
                cmd.steps = STEP_W'(SW);
                unit_num = NUM_W'(d2_abs[SW-1:0]);
                unit_opnd = OPND_W'(d1_mag_reg);
                state_next = S_M2_MUL;
            end
            S_M2_MUL:
            begin
                if (unit_done)
                begin
                    m2_next = m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
                    state_next = S_IDLE;
                end
            end
            S_VAR_DIV:
            begin
                if (unit_done)
                begin
                    cmd.start = 1'b1;
                    cmd.op = rmv_pkg::OP_SQRT;
                    cmd.steps = STEP_W'(ROOT_W);
                    unit_num = unit_quo;
                    state_next = S_STD_SQRT;
                end
            end
            S_STD_SQRT:
            begin
                if (unit_done)
                begin
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        sample_count_next = '0;
                        mean_value_next = '0;
                        std_next = '0;
                        smallest_next = '0;
                        largest_next = '0;
                        is_empty_next = 1'b1;
                    end
                    else
                    begin
                        sample_count_next = count_ext[CO_W-1:0];
                        mean_value_next = mean_ext[DW-1:0];
                        std_next = DW'(unit_root);
                        smallest_next = min_ext[DW-1:0];
                        largest_next = max_ext[DW-1:0];
                        is_empty_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            mean_reg <= '0;
            m2_reg <= '0;
            min_reg <= {1'b0, {(SW - 1){1'b1}}};
            max_reg <= {1'b1, {(SW - 1){1'b0}}};
            x_reg <= '0;
            d1_neg_reg <= 1'b0;
            d1_mag_reg <= '0;
            out_valid_reg <= 1'b0;
            sample_count_reg <= '0;
            mean_value_reg <= '0;
            std_reg <= '0;
            smallest_reg <= '0;
            largest_reg <= '0;
            is_empty_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            mean_reg <= mean_next;
            m2_reg <= m2_next;
            min_reg <= min_next;
            max_reg <= max_next;
            x_reg <= x_next;
            d1_neg_reg <= d1_neg_next;
            d1_mag_reg <= d1_mag_next;
            out_valid_reg <= out_valid_next;
            sample_count_reg <= sample_count_next;
            mean_value_reg <= mean_value_next;
            std_reg <= std_next;
            smallest_reg <= smallest_next;
            largest_reg <= largest_next;
            is_empty_reg <= is_empty_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample_count = sample_count_reg;
    assign mean_value = mean_value_reg;
    assign std_deviation = std_reg;
    assign smallest = smallest_reg;
    assign largest = largest_reg;
    assign is_empty = is_empty_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CW'(1)) || (count_reg == '0))
        else $error("sample count moved by other than one step or a clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("running minimum above running maximum");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0 && state_reg == S_IDLE) |->
            (mean_reg >= min_reg) && (mean_reg <= max_reg))
        else $error("running mean outside the sample range");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_REPORT))
        else $error("result raised outside the report state");

endmodule
